// File: design/mmalu_pkg.sv
`default_nettype none

package mmalu_pkg;

   localparam int OFFSET_WIDTH = 3;
   localparam int FLAG_WIDTH = 4;
   localparam int WINDOW_LOW_BITS = 4;

   typedef struct packed {
      logic o;
      logic n;
      logic c;
      logic z;
   } flags_type;

   typedef enum logic [OFFSET_WIDTH-1:0] {
      WR_LOAD = 3'd0,
      WR_SUB  = 3'd1,
      WR_RSUB = 3'd2,
      WR_ADD  = 3'd3,
      WR_XOR  = 3'd4,
      WR_AND  = 3'd5,
      WR_OR   = 3'd6,
      WR_SHR  = 3'd7
   } wr_op_type;

   typedef enum logic [OFFSET_WIDTH-1:0] {
      RD_ACC = 3'd0,
      RD_N   = 3'd1,
      RD_Z   = 3'd2,
      RD_O   = 3'd3,
      RD_C   = 3'd4,
      RD_LT  = 3'd5,
      RD_LE  = 3'd6,
      RD_CNZ = 3'd7
   } rd_op_type;

endpackage

`default_nettype wire

// File: design/mmalu_exec.sv
`default_nettype none

module mmalu_exec
   import mmalu_pkg::*;
#(
   parameter int WORD_WIDTH = 16
) (
   input  wire logic [WORD_WIDTH-1:0] acc_ff,
   input  wire flags_type             flags_ff,
   input  wire logic                  is_write,
   input  wire logic [WORD_WIDTH-1:0] address,
   input  wire logic [WORD_WIDTH-1:0] write_data,
   output logic      [WORD_WIDTH-1:0] acc_in,
   output flags_type                  flags_in,
   output logic      [WORD_WIDTH-1:0] read_data,
   output logic                       hit
);

   logic [OFFSET_WIDTH-1:0] offset;
   logic [WORD_WIDTH-1:0]   add_a;
   logic [WORD_WIDTH-1:0]   add_b;
   logic                    add_cin;
   logic [WORD_WIDTH:0]     add_sum;
   logic [WORD_WIDTH-1:0]   add_res;
   logic                    carry_top;
   flags_type               add_flags;
   logic                    cond;

   assign hit = (&address[WORD_WIDTH-1:WINDOW_LOW_BITS]) & ~address[OFFSET_WIDTH];
   assign offset = address[OFFSET_WIDTH-1:0];

   always_comb begin
      add_a = acc_ff;
      add_b = write_data;
      add_cin = 1'b0;
      case (wr_op_type'(offset))
         WR_SUB: begin
            add_b = ~write_data;
            add_cin = 1'b1;
         end
         WR_RSUB: begin
            add_a = write_data;
            add_b = ~acc_ff;
            add_cin = 1'b1;
         end
         default: begin
            add_a = acc_ff;
            add_b = write_data;
         end
      endcase
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{WORD_WIDTH{1'b0}}, add_cin};
   assign add_res = add_sum[WORD_WIDTH-1:0];
   assign carry_top = add_a[WORD_WIDTH-1] ^ add_b[WORD_WIDTH-1] ^ add_sum[WORD_WIDTH-1];

   always_comb begin
      add_flags.c = add_sum[WORD_WIDTH];
      add_flags.o = add_sum[WORD_WIDTH] ^ carry_top;
      add_flags.z = (add_res == '0);
      add_flags.n = add_res[WORD_WIDTH-1];
   end

   always_comb begin
      acc_in = acc_ff;
      flags_in = flags_ff;
      if (hit && is_write) begin
         unique case (wr_op_type'(offset))
            WR_LOAD: acc_in = write_data;
            WR_SUB, WR_RSUB, WR_ADD: begin
               acc_in = add_res;
               flags_in = add_flags;
            end
            WR_XOR: acc_in = acc_ff ^ write_data;
            WR_AND: acc_in = acc_ff & write_data;
            WR_OR:  acc_in = acc_ff | write_data;
            WR_SHR: acc_in = write_data >> 1;
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_comb begin
      unique case (rd_op_type'(offset))
         RD_N:   cond = flags_ff.n;
         RD_Z:   cond = flags_ff.z;
         RD_O:   cond = flags_ff.o;
         RD_C:   cond = flags_ff.c;
         RD_LT:  cond = flags_ff.n ^ flags_ff.o;
         RD_LE:  cond = (flags_ff.n ^ flags_ff.o) | flags_ff.z;
         RD_CNZ: cond = flags_ff.c ^ ~flags_ff.z;
         default: cond = 1'b0;
      endcase
   end

   always_comb begin
      read_data = '0;
      if (hit && !is_write) begin
         if (rd_op_type'(offset) == RD_ACC) begin
            read_data = acc_ff;
         end else begin
            read_data = {{(WORD_WIDTH-2){1'b0}}, cond, 1'b0};
         end
      end
   end

endmodule

`default_nettype wire

// File: design/move_machine_mapped_alu_core.sv
`default_nettype none

// Memory-mapped ALU for a one-instruction move machine. Each request is one bus access (read
// or write) and yields exactly one response carrying the read data, a window hit flag, the
// accumulator and the four flags after the access. The ALU answers in eight words within the
// top sixteen words of the address space, at all-ones minus 15 up to all-ones minus 8. A request
// is taken every cycle while the response side keeps up. It is held in the input register and
// is then executed into the response register, from which the response is sent. A stalled
// response holds both registers, and the input stalls once two requests are waiting.

module move_machine_mapped_alu_core
   import mmalu_pkg::*;
#(
   parameter int WORD_WIDTH = 16,
   localparam int REQ_DATA_WIDTH = ((2 * WORD_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH = ((2 * WORD_WIDTH + FLAG_WIDTH + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // address, write_data
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // kind
   input  wire logic                      req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // read_data, accumulator_out, flags_out
   output logic      [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // hit
   output logic                           rsp_tuser
);

   logic                  s1_valid_ff;
   logic                  s1_kind_ff;
   logic [WORD_WIDTH-1:0] s1_addr_ff;
   logic [WORD_WIDTH-1:0] s1_wdata_ff;
   logic [WORD_WIDTH-1:0] acc_ff;
   logic [WORD_WIDTH-1:0] acc_in;
   flags_type             flags_ff;
   flags_type             flags_in;
   logic [WORD_WIDTH-1:0] rd_in;
   logic                  hit_in;
   logic                  rsp_valid_ff;
   logic [WORD_WIDTH-1:0] rsp_rd_ff;
   logic                  rsp_hit_ff;
   logic [WORD_WIDTH-1:0] rsp_acc_ff;
   flags_type             rsp_flags_ff;
   logic                  s2_ready;
   logic                  s2_fire;
   logic                  req_fire;

   assign s2_ready = !rsp_valid_ff || rsp_tready;
   assign s2_fire = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_tuser;
         s1_addr_ff <= req_tdata[WORD_WIDTH-1:0];
         s1_wdata_ff <= req_tdata[2*WORD_WIDTH-1:WORD_WIDTH];
      end
   end

   mmalu_exec #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_exec (
      .acc_ff    (acc_ff),
      .flags_ff  (flags_ff),
      .is_write  (s1_kind_ff),
      .address   (s1_addr_ff),
      .write_data(s1_wdata_ff),
      .acc_in    (acc_in),
      .flags_in  (flags_in),
      .read_data (rd_in),
      .hit       (hit_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         flags_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s2_fire) begin
            acc_ff <= acc_in;
            flags_ff <= flags_in;
         end
         if (s2_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_rd_ff <= rd_in;
         rsp_hit_ff <= hit_in;
         rsp_acc_ff <= acc_in;
         rsp_flags_ff <= flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DATA_WIDTH'({rsp_flags_ff, rsp_acc_ff, rsp_rd_ff});
   assign rsp_tuser = rsp_hit_ff;

   a_miss_keeps_state: assert property (@(posedge clock) disable iff (reset)
      s2_fire && !hit_in |=> $stable(acc_ff) && $stable(flags_ff))
      else $error("An access outside the window changed the ALU state.");

   a_miss_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_rd_ff == '0)
      else $error("A response outside the window carries read data.");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      s2_fire |=> rsp_acc_ff == acc_ff && rsp_flags_ff == flags_ff)
      else $error("The response does not reflect the stored accumulator and flags.");

   a_stalled_request_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("A stalled request was lost from the input register.");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mmalu_pkg::*;

   localparam int REQ_DATA_WIDTH = 32;
   localparam int RSP_DATA_WIDTH = 40;
   localparam int RANDOM_REQUESTS = 1950;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_WRITE = 1'b1;
   localparam logic [12:0] WINDOW_TOP = 13'h1FFE;
   localparam logic [15:0] WINDOW_BASE = {WINDOW_TOP, 3'b000};

   typedef struct packed {
      logic [15:0] read_data;
      logic        hit;
      logic [15:0] acc;
      flags_type   flags;
   } access_result_type;

   typedef struct packed {
      logic              kind;
      logic [15:0]       address;
      logic [15:0]       data;
      logic              typed;
      access_result_type want;
   } request_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tuser;

   logic [15:0] alu_acc = '0;
   flags_type alu_flags = '0;
   access_result_type expected_results[$];
   int error_count = 0;
   bit long_hold_pending = 1'b0;

   request_row_type directed_rows [25] = '{
      '{KIND_READ,  {WINDOW_TOP, RD_ACC}, 16'h1234, 1'b1, '{16'h0000, 1'b1, 16'h0000, 4'b0000}},
      '{KIND_READ,  {WINDOW_TOP, RD_Z},   16'hFFFF, 1'b1, '{16'h0000, 1'b1, 16'h0000, 4'b0000}},
      '{KIND_READ,  {WINDOW_TOP, RD_CNZ}, 16'h0000, 1'b1, '{16'h0002, 1'b1, 16'h0000, 4'b0000}},
      '{KIND_WRITE, {WINDOW_TOP, WR_LOAD}, 16'hFFFF, 1'b1, '{16'h0000, 1'b1, 16'hFFFF, 4'b0000}},
      '{KIND_WRITE, {WINDOW_TOP, WR_ADD}, 16'h0001, 1'b1, '{16'h0000, 1'b1, 16'h0000, 4'b0011}},
      '{KIND_READ,  {WINDOW_TOP, RD_N},   16'h0000, 1'b0, '0},
      '{KIND_READ,  {WINDOW_TOP, RD_Z},   16'h0000, 1'b1, '{16'h0002, 1'b1, 16'h0000, 4'b0011}},
      '{KIND_READ,  {WINDOW_TOP, RD_C},   16'h0000, 1'b0, '0},
      '{KIND_READ,  {WINDOW_TOP, RD_CNZ}, 16'h0000, 1'b0, '0},
      '{KIND_WRITE, {WINDOW_TOP, WR_LOAD}, 16'h7FFF, 1'b1, '{16'h0000, 1'b1, 16'h7FFF, 4'b0011}},
      '{KIND_WRITE, {WINDOW_TOP, WR_ADD}, 16'h0001, 1'b1, '{16'h0000, 1'b1, 16'h8000, 4'b1100}},
      '{KIND_READ,  {WINDOW_TOP, RD_O},   16'h0000, 1'b0, '0},
      '{KIND_READ,  {WINDOW_TOP, RD_LT},  16'h0000, 1'b0, '0},
      '{KIND_READ,  {WINDOW_TOP, RD_LE},  16'h0000, 1'b0, '0},
      '{KIND_WRITE, {WINDOW_TOP, WR_SUB}, 16'h8000, 1'b0, '0},
      '{KIND_WRITE, {WINDOW_TOP, WR_RSUB}, 16'h0000, 1'b0, '0},
      '{KIND_WRITE, {WINDOW_TOP, WR_XOR}, 16'hFFFF, 1'b0, '0},
      '{KIND_WRITE, {WINDOW_TOP, WR_AND}, 16'h00FF, 1'b0, '0},
      '{KIND_WRITE, {WINDOW_TOP, WR_OR},  16'hF0F0, 1'b0, '0},
      '{KIND_WRITE, {WINDOW_TOP, WR_SHR}, 16'hFFFF, 1'b0, '0},
      '{KIND_WRITE, WINDOW_BASE - 16'd1,  16'h1234, 1'b0, '0},
      '{KIND_WRITE, WINDOW_BASE + 16'd8,  16'h5678, 1'b0, '0},
      '{KIND_READ,  16'h0000,             16'hFFFF, 1'b0, '0},
      '{KIND_READ,  16'hFFFF,             16'h0000, 1'b0, '0},
      '{KIND_READ,  {WINDOW_TOP, RD_ACC}, 16'h0000, 1'b0, '0}
   };

   move_machine_mapped_alu_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic logic [15:0] add_setting_flags(input logic [15:0] a, input logic [15:0] b,
                                                     input logic carry_in);
      logic [15:0] low;
      logic [1:0] top;
      logic [15:0] sum;
      low = {1'b0, a[14:0]} + {1'b0, b[14:0]} + {15'd0, carry_in};
      top = {1'b0, a[15]} + {1'b0, b[15]} + {1'b0, low[15]};
      sum = {top[0], low[14:0]};
      alu_flags.c = top[1];
      alu_flags.o = top[1] ^ low[15];
      alu_flags.z = (sum == 16'd0);
      alu_flags.n = sum[15];
      return sum;
   endfunction

   function automatic logic [15:0] cond_word(input logic condition);
      return {14'd0, condition, 1'b0};
   endfunction

   function automatic access_result_type predict_access(input logic kind,
                                                        input logic [15:0] address,
                                                        input logic [15:0] data);
      access_result_type result;
      result = '0;
      result.hit = (address >= WINDOW_BASE) && (address <= WINDOW_BASE + 16'd7);
      if (result.hit && kind == KIND_WRITE) begin
         case (wr_op_type'(address[2:0]))
            WR_LOAD: alu_acc = data;
            WR_SUB:  alu_acc = add_setting_flags(alu_acc, ~data, 1'b1);
            WR_RSUB: alu_acc = add_setting_flags(data, ~alu_acc, 1'b1);
            WR_ADD:  alu_acc = add_setting_flags(alu_acc, data, 1'b0);
            WR_XOR:  alu_acc = alu_acc ^ data;
            WR_AND:  alu_acc = alu_acc & data;
            WR_OR:   alu_acc = alu_acc | data;
            default: alu_acc = data >> 1;
         endcase
      end else if (result.hit) begin
         case (rd_op_type'(address[2:0]))
            RD_ACC:  result.read_data = alu_acc;
            RD_N:    result.read_data = cond_word(alu_flags.n);
            RD_Z:    result.read_data = cond_word(alu_flags.z);
            RD_O:    result.read_data = cond_word(alu_flags.o);
            RD_C:    result.read_data = cond_word(alu_flags.c);
            RD_LT:   result.read_data = cond_word(alu_flags.n ^ alu_flags.o);
            RD_LE:   result.read_data = cond_word((alu_flags.n ^ alu_flags.o) | alu_flags.z);
            default: result.read_data = cond_word(alu_flags.c ^ ~alu_flags.z);
         endcase
      end
      result.acc = alu_acc;
      result.flags = alu_flags;
      return result;
   endfunction

   task automatic send_request(input logic kind, input logic [15:0] address,
                               input logic [15:0] data, input logic typed,
                               input access_result_type want);
      access_result_type predicted;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {data, address};
      do @(posedge clock); while (!req_tready);
      predicted = predict_access(kind, address, data);
      expected_results.push_back(typed ? want : predicted);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   always @(posedge clock) begin
      access_result_type seen;
      access_result_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.read_data = rsp_tdata[15:0];
         seen.hit = rsp_tuser;
         seen.acc = rsp_tdata[31:16];
         seen.flags = rsp_tdata[35:32];
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected response: read_data %h hit %b acc %h flags %b",
                        seen.read_data, seen.hit, seen.acc, seen.flags);
            end
         end else begin
            wanted = expected_results.pop_front();
            if (seen.read_data !== wanted.read_data || seen.hit !== wanted.hit ||
                seen.acc !== wanted.acc || seen.flags !== wanted.flags) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: read_data %h/%h hit %b/%b acc %h/%h flags %b/%b",
                           wanted.read_data, seen.read_data, wanted.hit, seen.hit,
                           wanted.acc, seen.acc, wanted.flags, seen.flags);
               end
            end
         end
      end
   end

   // The receiver keeps its own stall pattern and takes a long break when asked.
   initial begin
      logic [15:0] stall_pattern;
      int cycle_count;
      stall_pattern = 16'hFFFF;
      cycle_count = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (cycle_count % 128 == 0) begin
               case ($urandom_range(0, 3))
                  0: stall_pattern = 16'hFFFF;
                  1: stall_pattern = 16'($urandom);
                  2: stall_pattern = 16'($urandom | $urandom);
                  default: stall_pattern = 16'($urandom & $urandom);
               endcase
               if (stall_pattern == 16'd0) begin
                  stall_pattern = 16'd1;
               end
            end
            rsp_tready <= stall_pattern[cycle_count % 16];
            cycle_count++;
            @(posedge clock);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      int burst_left;
      int gap;
      logic kind;
      logic [15:0] address;
      logic [15:0] data;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].kind, directed_rows[i].address, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);
      end
      burst_left = 0;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         if (i == 600) begin
            long_hold_pending = 1'b1;
         end
         if (i == 1300) begin
            drain_results();
         end
         kind = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 19))
            0, 1:    address = 16'($urandom);
            2:       address = WINDOW_BASE - 16'd16 + 16'($urandom_range(0, 31));
            default: address = {WINDOW_TOP, 3'($urandom_range(0, 7))};
         endcase
         case ($urandom_range(0, 11))
            0:       data = 16'h0000;
            1:       data = 16'hFFFF;
            2:       data = 16'h8000;
            3:       data = 16'h7FFF;
            4:       data = 16'h0001;
            5:       data = alu_acc;
            6:       data = ~alu_acc;
            default: data = 16'($urandom);
         endcase
         send_request(kind, address, data, 1'b0, '0);
      end
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
design/mmalu_pkg.sv
design/mmalu_exec.sv
design/move_machine_mapped_alu_core.sv
tb/sv/testbench.sv
